[hw/rtl/bspu_pkg.sv]
// ---------------------------------------------------------------------------
// bspu_pkg
// Shared types and codes for the bit stream packer / unpacker.
// ---------------------------------------------------------------------------
package bspu_pkg;

    localparam int WORD_BITS = 64;
    localparam int CAP_W     = 11;
    localparam int FUNC_W    = 3;
    localparam int OFF_W     = 6;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 13;
    localparam int STAT_W    = 2;

    // APB register map
    localparam int                ADDR_W       = 3;
    localparam logic [ADDR_W-3:0] REG_CAPACITY = 1'b0;
    localparam logic [CAP_W-1:0]  CAP_RESET    = 11'd1024;

    // function codes
    localparam logic [FUNC_W-1:0] FN_APPEND     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_RETRIEVE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SET_BIT    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_TEST_BIT   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_REWIND_RD  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SKIP_BYTE  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_REWIND_ALL = 3'd6;
    localparam logic [FUNC_W-1:0] FN_CLEAR      = 3'd7;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_END   = 2'd2;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [WORD_BITS-1:0] data_in;
        logic [OFF_W-1:0]     bit_offset;
        logic [CNT_W-1:0]     bit_count;
        logic [IDX_W-1:0]     bit_index;
    } req_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] data_out;
        logic                 bit_value;
        logic [STAT_W-1:0]    status;
    } rsp_t;

endpackage

[hw/rtl/bit_stream_packer_unpacker.sv]
// ---------------------------------------------------------------------------
// bit_stream_packer_unpacker
// MSB-first bit stream writer and reader over a single-port byte store.
// ---------------------------------------------------------------------------
//  channel | signals                          | direction | word
//  --------+----------------------------------+-----------+-----------------
//  req     | req_valid, req_ready, req        | in        | bspu_pkg::req_t
//  rsp     | rsp_valid, rsp_ready, rsp        | out       | bspu_pkg::rsp_t
//  apb     | psel, penable, pwrite, paddr,    | in / out  | capacity register
//          | pwdata, prdata, pready           |           |
//
// One word at a time; the byte store moves one byte per cycle. With nb =
// bytes touched (1..9): append writes nb bytes, retrieve reads nb bytes and
// aligns them, set/test bit reads then sets or tests a bit, clear zeroes all.
// After reset a pass clearing all STORE_BYTES bytes runs before req_ready rises.
// The result sits in an output register, so the next word is taken while it
// waits; a finished word stalls only if the previous result is still held.
module bit_stream_packer_unpacker #(
    parameter int STORE_BYTES = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    output logic                        req_ready,
    input  bspu_pkg::req_t              req,
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output bspu_pkg::rsp_t              rsp,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bspu_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int ABITS = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int POS_W = (ABITS + 4 > 15) ? ABITS + 4 : 15;
    localparam int WB    = bspu_pkg::WORD_BITS;
    localparam int WIN_W = WB + 8;
    localparam logic [ABITS-1:0] LAST_ADDR = ABITS'(STORE_BYTES - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CLR      = 4'd1;
    localparam logic [3:0] S_DECODE   = 4'd2;
    localparam logic [3:0] S_AP_SHIFT = 4'd3;
    localparam logic [3:0] S_AP_RD    = 4'd4;
    localparam logic [3:0] S_AP_WR    = 4'd5;
    localparam logic [3:0] S_RD_LOOP  = 4'd6;
    localparam logic [3:0] S_RD_ALIGN = 4'd7;
    localparam logic [3:0] S_RD_PLACE = 4'd8;
    localparam logic [3:0] S_BIT_RD   = 4'd9;
    localparam logic [3:0] S_BIT_WR   = 4'd10;
    localparam logic [3:0] S_DONE     = 4'd11;

    // control
    logic [3:0]                     state_reg, state_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [bspu_pkg::CAP_W-1:0]     capacity_reg, capacity_next;
    logic [POS_W-1:0]               wtot_reg, wtot_next;
    logic [POS_W-1:0]               rtot_reg, rtot_next;
    logic                           clr_item_reg, clr_item_next;
    logic [ABITS-1:0]               addr_reg, addr_next;
    logic                           pend_reg, pend_next;

    // payload
    logic [bspu_pkg::FUNC_W-1:0]    func_reg, func_next;
    logic [WB-1:0]                  data_reg, data_next;
    logic [bspu_pkg::OFF_W-1:0]     off_reg, off_next;
    logic [bspu_pkg::CNT_W-1:0]     cnt_reg, cnt_next;
    logic [bspu_pkg::IDX_W-1:0]     idx_reg, idx_next;
    logic [2:0]                     sub_reg, sub_next;
    logic [3:0]                     nb_reg, nb_next;
    logic [3:0]                     cnt_j_reg, cnt_j_next;
    logic [WIN_W-1:0]               win_reg, win_next;
    logic [WB-1:0]                  res_data_reg, res_data_next;
    logic                           res_bit_reg, res_bit_next;
    logic [bspu_pkg::STAT_W-1:0]    res_status_reg, res_status_next;
    bspu_pkg::rsp_t                 rsp_reg, rsp_next;

    // store
    logic [7:0]                     mem [STORE_BYTES];
    logic [7:0]                     mem_q;
    logic                           mem_we;
    logic [7:0]                     mem_wdata;

    // datapath helpers
    logic                           cfg_we;
    logic [bspu_pkg::CNT_W-1:0]     room;
    logic [bspu_pkg::CNT_W-1:0]     cnt_cut;
    logic [POS_W-1:0]               cap_ext;
    logic [POS_W-1:0]               cap_bits;
    logic [POS_W-1:0]               wtot_plus;
    logic [POS_W-1:0]               rtot_plus;
    logic [POS_W-1:0]               idx_ext;
    logic [2:0]                     sel_sub;
    logic [bspu_pkg::CNT_W-1:0]     nb_sum;
    logic [WB-1:0]                  top_mask;
    logic [bspu_pkg::CNT_W-1:0]     rd_sh;
    logic [WIN_W-1:0]               rd_full;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign pready    = 1'b1;

    assign cfg_we = psel & penable & pwrite
                  & (paddr[bspu_pkg::ADDR_W-1:2] == bspu_pkg::REG_CAPACITY);

    always_comb
    begin
        if (paddr[bspu_pkg::ADDR_W-1:2] == bspu_pkg::REG_CAPACITY)
            prdata = 32'(capacity_reg);
        else
            prdata = '0;
    end

    // field length is cut to what is left of the word after the offset
    assign room    = bspu_pkg::CNT_W'(WB) - bspu_pkg::CNT_W'(req.bit_offset);
    assign cnt_cut = (req.bit_count > room) ? room : req.bit_count;

    assign cap_ext   = POS_W'(capacity_reg);
    assign cap_bits  = ((cap_ext > POS_W'(STORE_BYTES)) ? POS_W'(STORE_BYTES) : cap_ext) << 3;
    assign wtot_plus = wtot_reg + POS_W'(cnt_reg);
    assign rtot_plus = rtot_reg + POS_W'(cnt_reg);
    assign idx_ext   = POS_W'(idx_reg);
    assign sel_sub   = (func_reg == bspu_pkg::FN_APPEND) ? wtot_reg[2:0] : rtot_reg[2:0];
    assign nb_sum    = bspu_pkg::CNT_W'(sel_sub) + cnt_reg + bspu_pkg::CNT_W'(7);
    assign top_mask  = ~({WB{1'b1}} >> cnt_reg);

    // left-align the gathered bytes so the field's first bit lands on the MSB
    assign rd_sh   = bspu_pkg::CNT_W'(WIN_W) - {nb_reg, 3'b000} + bspu_pkg::CNT_W'(sub_reg);
    assign rd_full = win_reg << rd_sh;

    always_comb
    begin
        state_next      = state_reg;
        rsp_valid_next  = rsp_valid_reg;
        capacity_next   = capacity_reg;
        wtot_next       = wtot_reg;
        rtot_next       = rtot_reg;
        clr_item_next   = clr_item_reg;
        addr_next       = addr_reg;
        pend_next       = pend_reg;
        func_next       = func_reg;
        data_next       = data_reg;
        off_next        = off_reg;
        cnt_next        = cnt_reg;
        idx_next        = idx_reg;
        sub_next        = sub_reg;
        nb_next         = nb_reg;
        cnt_j_next      = cnt_j_reg;
        win_next        = win_reg;
        res_data_next   = res_data_reg;
        res_bit_next    = res_bit_reg;
        res_status_next = res_status_reg;
        rsp_next        = rsp_reg;
        mem_we          = 1'b0;
        mem_wdata       = '0;

        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (cfg_we)
            capacity_next = pwdata[bspu_pkg::CAP_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next  = req.func;
                    data_next  = req.data_in;
                    off_next   = req.bit_offset;
                    cnt_next   = cnt_cut;
                    idx_next   = req.bit_index;
                    state_next = S_DECODE;
                end
            end

            S_CLR:
            begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                addr_next = addr_reg + 1'b1;
                if (addr_reg == LAST_ADDR)
                begin
                    clr_item_next = 1'b0;
                    state_next    = clr_item_reg ? S_DONE : S_IDLE;
                end
            end

            S_DECODE:
            begin
                res_data_next   = '0;
                res_bit_next    = 1'b0;
                res_status_next = bspu_pkg::STAT_OK;
                state_next      = S_DONE;
                sub_next        = sel_sub;
                nb_next         = nb_sum[6:3];
                cnt_j_next      = '0;
                pend_next       = 1'b0;
                unique case (func_reg) inside
                    bspu_pkg::FN_APPEND:
                    begin
                        if (cnt_reg == '0)
                            state_next = S_DONE;
                        else if (wtot_plus > cap_bits)
                            res_status_next = bspu_pkg::STAT_FULL;
                        else
                        begin
                            addr_next  = ABITS'(wtot_reg >> 3);
                            wtot_next  = wtot_plus;
                            state_next = S_AP_SHIFT;
                        end
                    end
                    bspu_pkg::FN_RETRIEVE:
                    begin
                        if (cnt_reg == '0)
                            state_next = S_DONE;
                        else if ((rtot_reg > wtot_reg)
                                 || ((wtot_reg - rtot_reg) < POS_W'(cnt_reg)))
                            res_status_next = bspu_pkg::STAT_END;
                        else
                        begin
                            addr_next  = ABITS'(rtot_reg >> 3);
                            rtot_next  = rtot_plus;
                            state_next = S_RD_LOOP;
                        end
                    end
                    bspu_pkg::FN_SET_BIT, bspu_pkg::FN_TEST_BIT:
                    begin
                        if (idx_ext >= cap_bits)
                            res_status_next = bspu_pkg::STAT_RANGE;
                        else
                        begin
                            addr_next  = ABITS'(idx_ext >> 3);
                            sub_next   = idx_reg[2:0];
                            state_next = S_BIT_RD;
                        end
                    end
                    bspu_pkg::FN_REWIND_RD:
                        rtot_next = '0;
                    bspu_pkg::FN_SKIP_BYTE:
                    begin
                        if (rtot_reg[2:0] != 3'b000)
                            rtot_next = {rtot_reg[POS_W-1:3] + 1'b1, 3'b000};
                    end
                    bspu_pkg::FN_REWIND_ALL:
                    begin
                        rtot_next = '0;
                        wtot_next = '0;
                    end
                    bspu_pkg::FN_CLEAR:
                    begin
                        rtot_next     = '0;
                        wtot_next     = '0;
                        addr_next     = '0;
                        clr_item_next = 1'b1;
                        state_next    = S_CLR;
                    end
                    default:
                        state_next = S_DONE;
                endcase
            end

            S_AP_SHIFT:
            begin
                data_next  = (data_reg << off_reg) & top_mask;
                state_next = S_AP_RD;
            end

            S_AP_RD:
            begin
                // read of the first byte is in flight; place field after old bits
                win_next   = {data_reg, 8'h00} >> sub_reg;
                state_next = S_AP_WR;
            end

            S_AP_WR:
            begin
                mem_we = 1'b1;
                if (cnt_j_reg == '0)
                    mem_wdata = win_reg[WIN_W-1:WIN_W-8] | (mem_q & ~(8'hFF >> sub_reg));
                else
                    mem_wdata = win_reg[WIN_W-1:WIN_W-8];
                win_next   = win_reg << 8;
                addr_next  = addr_reg + 1'b1;
                cnt_j_next = cnt_j_reg + 1'b1;
                if ((cnt_j_reg + 4'd1) == nb_reg)
                    state_next = S_DONE;
            end

            S_RD_LOOP:
            begin
                if (cnt_j_reg != nb_reg)
                begin
                    addr_next  = addr_reg + 1'b1;
                    cnt_j_next = cnt_j_reg + 1'b1;
                    pend_next  = 1'b1;
                end
                else
                    pend_next = 1'b0;
                if (pend_reg)
                    win_next = {win_reg[WIN_W-9:0], mem_q};
                if ((cnt_j_reg == nb_reg) && pend_reg)
                    state_next = S_RD_ALIGN;
            end

            S_RD_ALIGN:
            begin
                data_next  = rd_full[WIN_W-1:8] & top_mask;
                state_next = S_RD_PLACE;
            end

            S_RD_PLACE:
            begin
                res_data_next = data_reg >> off_reg;
                state_next    = S_DONE;
            end

            S_BIT_RD:
                state_next = S_BIT_WR;

            S_BIT_WR:
            begin
                if (func_reg == bspu_pkg::FN_SET_BIT)
                begin
                    mem_we    = 1'b1;
                    mem_wdata = mem_q | (8'h80 >> sub_reg);
                end
                else
                    res_bit_next = mem_q[3'd7 - sub_reg];
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next    = 1'b1;
                    rsp_next.data_out  = res_data_reg;
                    rsp_next.bit_value = res_bit_reg;
                    rsp_next.status    = res_status_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            rsp_valid_reg <= 1'b0;
            capacity_reg  <= bspu_pkg::CAP_RESET;
            wtot_reg      <= '0;
            rtot_reg      <= '0;
            clr_item_reg  <= 1'b0;
            addr_reg      <= '0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
            capacity_reg  <= capacity_next;
            wtot_reg      <= wtot_next;
            rtot_reg      <= rtot_next;
            clr_item_reg  <= clr_item_next;
            addr_reg      <= addr_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        data_reg       <= data_next;
        off_reg        <= off_next;
        cnt_reg        <= cnt_next;
        idx_reg        <= idx_next;
        sub_reg        <= sub_next;
        nb_reg         <= nb_next;
        cnt_j_reg      <= cnt_j_next;
        win_reg        <= win_next;
        res_data_reg   <= res_data_next;
        res_bit_reg    <= res_bit_next;
        res_status_reg <= res_status_next;
        rsp_reg        <= rsp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[addr_reg] <= mem_wdata;
        mem_q <= mem[addr_reg];
    end

endmodule

[tb/bit_stream_packer_unpacker_tb.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// bit_stream_packer_unpacker_tb
// Self-checking bench for the MSB-first bit stream packer / unpacker.
// A shadow copy of the byte store and both pointers predicts every response.
// Each accepted request word is run through that prediction, and each
// accepted response word is checked field by field against the oldest
// prediction. Requests and responses get random idle bursts except in the
// last phase; the capacity register is reprogrammed between phases once idle.
// ---------------------------------------------------------------------------
module bit_stream_packer_unpacker_tb;

    localparam int STORE_BYTES   = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int WB            = bspu_pkg::WORD_BITS;

    class stream_scoreboard;
        bit [7:0]                    shadow_bytes [STORE_BYTES];
        int unsigned                 wr_pos;
        int unsigned                 rd_byte;
        int unsigned                 rd_bit;
        int unsigned                 capacity;
        bspu_pkg::rsp_t              expected_results [$];
        logic [bspu_pkg::FUNC_W-1:0] expected_funcs [$];
        int                          errors;
        int                          func_count [8];
        int                          status_count [4];

        function new();
            foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
            foreach (func_count[i]) func_count[i] = 0;
            foreach (status_count[i]) status_count[i] = 0;
            wr_pos   = 0;
            rd_byte  = 0;
            rd_bit   = 0;
            capacity = 32'(bspu_pkg::CAP_RESET);
            errors   = 0;
        endfunction

        function int unsigned cap_bits();
            return ((capacity > STORE_BYTES) ? STORE_BYTES : capacity) * 8;
        endfunction

        function bit get_bit(int unsigned i);
            return shadow_bytes[i >> 3][7 - (i & 7)];
        endfunction

        function void put_bit(int unsigned i, bit v);
            shadow_bytes[i >> 3][7 - (i & 7)] = v;
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        // advance the shadow stream by one request and queue its response
        function void predict_result(bspu_pkg::req_t w);
            bspu_pkg::rsp_t r;
            int unsigned    off;
            int unsigned    cnt;
            int unsigned    rtot;
            int unsigned    k;
            r    = '0;
            off  = 32'(w.bit_offset);
            cnt  = 32'(w.bit_count);
            if (cnt > WB - off)
                cnt = WB - off;
            rtot = rd_byte * 8 + rd_bit;
            case (w.func)
                bspu_pkg::FN_APPEND:
                begin
                    if (cnt != 0)
                    begin
                        if (wr_pos + cnt > cap_bits())
                            r.status = bspu_pkg::STAT_FULL;
                        else
                        begin
                            for (k = 0; k < cnt; k++)
                                put_bit(wr_pos + k, w.data_in[WB - 1 - (off + k)]);
                            wr_pos += cnt;
                            // rest of the last byte is zeroed
                            for (k = wr_pos; (k & 7) != 0; k++)
                                put_bit(k, 1'b0);
                        end
                    end
                end
                bspu_pkg::FN_RETRIEVE:
                begin
                    if (cnt != 0)
                    begin
                        if (rtot > wr_pos || wr_pos - rtot < cnt)
                            r.status = bspu_pkg::STAT_END;
                        else
                        begin
                            for (k = 0; k < cnt; k++)
                                r.data_out[WB - 1 - (off + k)] = get_bit(rtot + k);
                            rtot   += cnt;
                            rd_byte = rtot >> 3;
                            rd_bit  = rtot & 7;
                        end
                    end
                end
                bspu_pkg::FN_SET_BIT:
                begin
                    if (w.bit_index >= cap_bits())
                        r.status = bspu_pkg::STAT_RANGE;
                    else
                        put_bit(32'(w.bit_index), 1'b1);
                end
                bspu_pkg::FN_TEST_BIT:
                begin
                    if (w.bit_index >= cap_bits())
                        r.status = bspu_pkg::STAT_RANGE;
                    else
                        r.bit_value = get_bit(32'(w.bit_index));
                end
                bspu_pkg::FN_REWIND_RD:
                begin
                    rd_byte = 0;
                    rd_bit  = 0;
                end
                bspu_pkg::FN_SKIP_BYTE:
                begin
                    if (rd_bit != 0)
                    begin
                        rd_byte = (rd_byte + 1) & 11'h7FF;
                        rd_bit  = 0;
                    end
                end
                bspu_pkg::FN_REWIND_ALL:
                begin
                    rd_byte = 0;
                    rd_bit  = 0;
                    wr_pos  = 0;
                end
                bspu_pkg::FN_CLEAR:
                begin
                    foreach (shadow_bytes[i]) shadow_bytes[i] = 8'h00;
                    rd_byte = 0;
                    rd_bit  = 0;
                    wr_pos  = 0;
                end
                default:
                begin
                end
            endcase
            func_count[w.func]++;
            status_count[r.status]++;
            expected_results.push_back(r);
            expected_funcs.push_back(w.func);
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(bspu_pkg::rsp_t got);
            bspu_pkg::rsp_t              want;
            logic [bspu_pkg::FUNC_W-1:0] f;
            if (expected_results.size() == 0)
            begin
                report($sformatf("response %h with nothing outstanding", got));
                return;
            end
            want = expected_results.pop_front();
            f    = expected_funcs.pop_front();
            if (got.data_out !== want.data_out)
                report($sformatf("func %0d data_out %h, want %h", f, got.data_out,
                                 want.data_out));
            if (got.bit_value !== want.bit_value)
                report($sformatf("func %0d bit_value %b, want %b", f, got.bit_value,
                                 want.bit_value));
            if (got.status !== want.status)
                report($sformatf("func %0d status %0d, want %0d", f, got.status,
                                 want.status));
        endtask
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          req_valid;
    logic                          req_ready;
    bspu_pkg::req_t                req;
    logic                          rsp_valid;
    logic                          rsp_ready;
    bspu_pkg::rsp_t                rsp;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [bspu_pkg::ADDR_W-1:0]   paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;

    bit                            idle_on;
    int unsigned                   cur_cap;
    stream_scoreboard              sb;

    bit_stream_packer_unpacker #(
        .STORE_BYTES(STORE_BYTES)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // response side: check accepted words, stall in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        rsp_ready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 19) - 1;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= 1'b1;
        end
    end

    function automatic bspu_pkg::req_t make_word(logic [bspu_pkg::FUNC_W-1:0] f,
                                                 logic [WB-1:0] d,
                                                 int off, int cnt, int idx);
        bspu_pkg::req_t w;
        w.func       = f;
        w.data_in    = d;
        w.bit_offset = bspu_pkg::OFF_W'(off);
        w.bit_count  = bspu_pkg::CNT_W'(cnt);
        w.bit_index  = bspu_pkg::IDX_W'(idx);
        return w;
    endfunction

    function automatic bspu_pkg::req_t random_word();
        bspu_pkg::req_t w;
        int unsigned    pick;
        int unsigned    lim;
        lim          = ((cur_cap > STORE_BYTES) ? STORE_BYTES : cur_cap) * 8;
        w.data_in    = {$urandom, $urandom};
        w.bit_offset = ($urandom_range(0, 3) == 0) ? '0
                     : bspu_pkg::OFF_W'($urandom_range(0, 63));
        // occasional zero or over-long counts exercise the field cut
        if ($urandom_range(0, 99) < 8)
            w.bit_count = bspu_pkg::CNT_W'($urandom_range(0, 127));
        else
            w.bit_count = bspu_pkg::CNT_W'($urandom_range(1, WB - w.bit_offset));
        if (lim == 0 || $urandom_range(0, 3) == 0)
            w.bit_index = bspu_pkg::IDX_W'($urandom_range(0, 8191));
        else
            w.bit_index = bspu_pkg::IDX_W'($urandom_range(0,
                                           (lim + 7 > 8191) ? 8191 : lim + 7));
        pick = $urandom_range(0, 99);
        if (pick < 34)
            w.func = bspu_pkg::FN_APPEND;
        else if (pick < 62)
            w.func = bspu_pkg::FN_RETRIEVE;
        else if (pick < 69)
            w.func = bspu_pkg::FN_SET_BIT;
        else if (pick < 79)
            w.func = bspu_pkg::FN_TEST_BIT;
        else if (pick < 86)
            w.func = bspu_pkg::FN_REWIND_RD;
        else if (pick < 92)
            w.func = bspu_pkg::FN_SKIP_BYTE;
        else if (pick < 98)
            w.func = bspu_pkg::FN_REWIND_ALL;
        else
            w.func = bspu_pkg::FN_CLEAR;
        return w;
    endfunction

    task automatic send_word(bspu_pkg::req_t w);
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sb.predict_result(w);
        if (idle_on && $urandom_range(0, 5) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // between phases: drain until idle, settle, then write and read back
    task automatic set_capacity(int unsigned value);
        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        paddr   <= {bspu_pkg::REG_CAPACITY, 2'b00};
        pwdata  <= value;
        pwrite  <= 1'b1;
        psel    <= 1'b1;
        penable <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.capacity = value & 11'h7FF;
        cur_cap     = value & 11'h7FF;
        @(posedge clk);
        psel <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== (value & 32'h7FF))
            sb.report($sformatf("capacity reads back %h, want %h", prdata, value & 32'h7FF));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic run_directed();
        send_word(make_word(bspu_pkg::FN_RETRIEVE, 64'h0, 0, 8, 0));      // empty stream
        send_word(make_word(bspu_pkg::FN_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 0, 64, 0));
        send_word(make_word(bspu_pkg::FN_APPEND, 64'h1, 63, 1, 0));
        send_word(make_word(bspu_pkg::FN_APPEND, 64'hA5C3_0F96_5A3C_F069, 5, 127, 0));
        send_word(make_word(bspu_pkg::FN_APPEND, 64'h1234, 10, 0, 0));    // zero count
        send_word(make_word(bspu_pkg::FN_RETRIEVE, 64'h0, 0, 64, 0));
        send_word(make_word(bspu_pkg::FN_RETRIEVE, 64'h0, 63, 1, 0));
        send_word(make_word(bspu_pkg::FN_RETRIEVE, 64'h0, 5, 100, 0));
        send_word(make_word(bspu_pkg::FN_RETRIEVE, 64'h0, 0, 0, 0));
        send_word(make_word(bspu_pkg::FN_RETRIEVE, 64'h0, 0, 1, 0));      // reader at writer
        send_word(make_word(bspu_pkg::FN_SKIP_BYTE, 64'h0, 0, 1, 0));     // reader passes
        send_word(make_word(bspu_pkg::FN_RETRIEVE, 64'h0, 0, 1, 0));
        send_word(make_word(bspu_pkg::FN_REWIND_RD, 64'h0, 0, 1, 0));
        send_word(make_word(bspu_pkg::FN_RETRIEVE, 64'h0, 32, 8, 0));
        send_word(make_word(bspu_pkg::FN_SKIP_BYTE, 64'h0, 0, 1, 0));     // aligned, stays
        send_word(make_word(bspu_pkg::FN_SET_BIT, 64'h0, 0, 1, 8191));
        send_word(make_word(bspu_pkg::FN_TEST_BIT, 64'h0, 0, 1, 8191));
        send_word(make_word(bspu_pkg::FN_TEST_BIT, 64'h0, 0, 1, 0));
        send_word(make_word(bspu_pkg::FN_REWIND_ALL, 64'h0, 0, 1, 0));
        send_word(make_word(bspu_pkg::FN_APPEND, 64'h0, 0, 3, 0));        // zeroes byte 0 tail
        send_word(make_word(bspu_pkg::FN_TEST_BIT, 64'h0, 0, 1, 5));
        send_word(make_word(bspu_pkg::FN_CLEAR, 64'h0, 0, 1, 0));
        send_word(make_word(bspu_pkg::FN_TEST_BIT, 64'h0, 0, 1, 8191));

        set_capacity(1);
        send_word(make_word(bspu_pkg::FN_SET_BIT, 64'h0, 0, 1, 8));
        send_word(make_word(bspu_pkg::FN_SET_BIT, 64'h0, 0, 1, 7));
        send_word(make_word(bspu_pkg::FN_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 0, 9, 0));
        send_word(make_word(bspu_pkg::FN_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 0, 8, 0));
        send_word(make_word(bspu_pkg::FN_APPEND, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 0));
        send_word(make_word(bspu_pkg::FN_TEST_BIT, 64'h0, 0, 1, 7));

        set_capacity(0);
        send_word(make_word(bspu_pkg::FN_APPEND, 64'h0, 0, 1, 0));
        send_word(make_word(bspu_pkg::FN_TEST_BIT, 64'h0, 0, 1, 0));
        send_word(make_word(bspu_pkg::FN_SET_BIT, 64'h0, 0, 1, 0));
        send_word(make_word(bspu_pkg::FN_RETRIEVE, 64'h0, 56, 8, 0));

        set_capacity(2047);                                     // clamps to store size
        send_word(make_word(bspu_pkg::FN_SET_BIT, 64'h0, 0, 1, 8191));
        send_word(make_word(bspu_pkg::FN_TEST_BIT, 64'h0, 0, 1, 8191));
        send_word(make_word(bspu_pkg::FN_APPEND, 64'h8000_0000_0000_0001, 0, 64, 0));
    endtask

    task automatic run_random_phase(int unsigned cap, int n);
        set_capacity(cap);
        repeat (n) send_word(random_word());
    endtask

    initial
    begin
        sb        = new();
        idle_on   = 1'b1;
        cur_cap   = 32'(bspu_pkg::CAP_RESET);
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random_phase(1024, 110);
        run_random_phase(5, 50);      // below the write pointer left by the last phase
        run_random_phase(2047, 70);
        run_random_phase(1, 40);
        run_random_phase(64, 70);
        idle_on = 1'b0;
        run_random_phase(333, 60);

        req_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $write("covered: append %0d, retrieve %0d, set %0d, test %0d,",
               sb.func_count[0], sb.func_count[1], sb.func_count[2], sb.func_count[3]);
        $display(" rewind rd %0d, skip %0d, rewind all %0d, clear %0d",
                 sb.func_count[4], sb.func_count[5], sb.func_count[6], sb.func_count[7]);
        $write("answers: ok %0d, full %0d, end of data %0d,",
               sb.status_count[0], sb.status_count[1], sb.status_count[2]);
        $display(" out of range %0d; capacities 0..2047", sb.status_count[3]);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
